[src/ipsc_pkg.sv]
// Shared definitions for the inactivity power state controller.
// Power state codes, command codes and configuration reset values.
// No dependencies.
package ipsc_pkg;

    // Power state codes
    localparam logic [1:0] ST_ACTIVE  = 2'd0;
    localparam logic [1:0] ST_DISPOFF = 2'd1;
    localparam logic [1:0] ST_IDLE    = 2'd2;
    localparam logic [1:0] ST_SLEEP   = 2'd3;

    // Command codes
    localparam logic [2:0] CMD_UPDATE    = 3'd0;
    localparam logic [2:0] CMD_ACTIVITY  = 3'd1;
    localparam logic [2:0] CMD_DISP_ACT  = 3'd2;
    localparam logic [2:0] CMD_FORCE     = 3'd3;
    localparam logic [2:0] CMD_EMERGENCY = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_DISPLAY_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_IDLE_TIMEOUT    = 2'd1;
    localparam logic [1:0] CFG_DISPLAY_WAKE    = 2'd2;
    localparam logic [1:0] CFG_IDLE_WAKE       = 2'd3;

    // Configuration reset values (ms)
    localparam logic [31:0] RST_DISPLAY_TIMEOUT = 32'd30000;
    localparam logic [31:0] RST_IDLE_TIMEOUT    = 32'd300000;
    localparam logic [31:0] RST_DISPLAY_WAKE    = 32'd1000;
    localparam logic [31:0] RST_IDLE_WAKE       = 32'd5000;

    // Power-saving flags
    typedef struct packed {
        logic display;
        logic low_clock;
        logic wifi_save;
        logic ble_save;
    } t_flags;

    localparam t_flags FLAGS_RESET = '{display: 1'b1, low_clock: 1'b0,
                                       wifi_save: 1'b0, ble_save: 1'b0};

endpackage

[src/inactivity_power_state_controller_top.sv]
// An accepted transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle while the result channel does not stall; the state
// update for one transaction is a pair of 32-bit subtracts and compares, all combinational.
// Reset: synchronous, active low; power state returns to active, display on, other
// flags off, timestamps zero and configuration registers to their default values.
// Holds the whole controller; depends on ipsc_pkg.
module inactivity_power_state_controller_top
    import ipsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_now_ms,
    input  logic [1:0]  i_target_state,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_power_state,
    output logic        o_display_on,
    output logic        o_cpu_low_clock,
    output logic        o_wifi_save_on,
    output logic        o_ble_save_on,
    output logic        o_sleep_request
);

    // configuration registers
    logic [31:0] r_display_timeout;
    logic [31:0] r_idle_timeout;
    logic [31:0] r_display_wake;
    logic [31:0] r_idle_wake;

    // input register
    logic        r_in_valid;
    logic [2:0]  r_command;
    logic [31:0] r_now_ms;
    logic [1:0]  r_target;

    // controller state
    logic [1:0]  r_mode,     n_mode;
    logic [31:0] r_last_any, n_last_any;
    logic [31:0] r_last_disp, n_last_disp;
    t_flags      r_flags,    n_flags;
    logic        n_pulse;

    // result register
    logic        r_out_valid;
    logic [1:0]  r_out_state;
    t_flags      r_out_flags;
    logic        r_out_pulse;

    logic        out_free;
    logic        fire;
    logic [31:0] since_any;
    logic [31:0] since_disp;
    logic        idle_to_sleep;
    logic [1:0]  force_tgt;
    logic        do_force;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display_timeout <= RST_DISPLAY_TIMEOUT;
            r_idle_timeout    <= RST_IDLE_TIMEOUT;
            r_display_wake    <= RST_DISPLAY_WAKE;
            r_idle_wake       <= RST_IDLE_WAKE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DISPLAY_TIMEOUT: r_display_timeout <= i_cfg_data;
                CFG_IDLE_TIMEOUT:    r_idle_timeout    <= i_cfg_data;
                CFG_DISPLAY_WAKE:    r_display_wake    <= i_cfg_data;
                CFG_IDLE_WAKE:       r_idle_wake       <= i_cfg_data;
            endcase
        end
    end

    // input register: refills whenever it is not held by a stalled result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_command <= i_command;
            r_now_ms  <= i_now_ms;
            r_target  <= i_target_state;
        end
    end

    // elapsed times, modulo 2^32; deep-sleep limit is twice the idle timeout in 33 bits
    assign since_any     = r_now_ms - r_last_any;
    assign since_disp    = r_now_ms - r_last_disp;
    assign idle_to_sleep = {1'b0, since_any} > {r_idle_timeout, 1'b0};

    // state update for the transaction in the input register
    always_comb begin
        n_mode      = r_mode;
        n_last_any  = r_last_any;
        n_last_disp = r_last_disp;
        n_flags     = r_flags;
        n_pulse     = 1'b0;
        do_force    = 1'b0;
        force_tgt   = r_target;

        unique case (r_command)
            CMD_UPDATE: begin
                unique case (r_mode)
                    ST_ACTIVE: begin
                        if (since_disp > r_display_timeout) begin
                            n_mode            = ST_DISPOFF;
                            n_flags.display   = 1'b0;
                            n_flags.low_clock = 1'b1;
                            n_flags.wifi_save = 1'b1;
                        end
                    end
                    ST_DISPOFF: begin
                        if (since_any > r_idle_timeout) begin
                            n_mode            = ST_IDLE;
                            n_flags.low_clock = 1'b1;
                            n_flags.wifi_save = 1'b1;
                            n_flags.ble_save  = 1'b1;
                        end else if (since_disp < r_display_wake) begin
                            n_mode          = ST_ACTIVE;
                            n_flags.display = 1'b1;
                        end
                    end
                    ST_IDLE: begin
                        if (idle_to_sleep) begin
                            n_mode  = ST_SLEEP;
                            n_pulse = 1'b1;
                        end else if (since_any < r_idle_wake) begin
                            do_force  = 1'b1;
                            force_tgt = ST_ACTIVE;
                        end
                    end
                    ST_SLEEP: begin
                    end
                endcase
            end
            CMD_ACTIVITY: begin
                n_last_any = r_now_ms;
                do_force   = 1'b1;
                force_tgt  = ST_ACTIVE;
            end
            CMD_DISP_ACT: begin
                n_last_any  = r_now_ms;
                n_last_disp = r_now_ms;
                do_force    = 1'b1;
                force_tgt   = ST_ACTIVE;
            end
            CMD_FORCE: begin
                do_force = 1'b1;
            end
            CMD_EMERGENCY: begin
                n_mode            = ST_IDLE;
                n_flags.display   = 1'b0;
                n_flags.low_clock = 1'b1;
                n_flags.wifi_save = 1'b1;
                n_flags.ble_save  = 1'b1;
            end
            default: begin
            end
        endcase

        // forced move; a force to the current state changes nothing
        if (do_force && (force_tgt != r_mode)) begin
            n_mode = force_tgt;
            unique case (force_tgt)
                ST_ACTIVE: begin
                    n_flags = FLAGS_RESET;
                end
                ST_DISPOFF: begin
                    n_flags.display   = 1'b0;
                    n_flags.low_clock = 1'b1;
                    n_flags.wifi_save = 1'b1;
                end
                ST_IDLE: begin
                    n_flags.display   = 1'b0;
                    n_flags.low_clock = 1'b1;
                    n_flags.wifi_save = 1'b1;
                    n_flags.ble_save  = 1'b1;
                end
                ST_SLEEP: begin
                    n_pulse = 1'b1;
                end
            endcase
        end
    end

    // controller state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= ST_ACTIVE;
            r_last_any  <= '0;
            r_last_disp <= '0;
            r_flags     <= FLAGS_RESET;
        end else if (fire) begin
            r_mode      <= n_mode;
            r_last_any  <= n_last_any;
            r_last_disp <= n_last_disp;
            r_flags     <= n_flags;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_state <= n_mode;
            r_out_flags <= n_flags;
            r_out_pulse <= n_pulse;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_power_state   = r_out_state;
    assign o_display_on    = r_out_flags.display;
    assign o_cpu_low_clock = r_out_flags.low_clock;
    assign o_wifi_save_on  = r_out_flags.wifi_save;
    assign o_ble_save_on   = r_out_flags.ble_save;
    assign o_sleep_request = r_out_pulse;

`ifndef ASSERT_OFF
    // a sleep request is only raised on a transaction that leaves a non-sleep state
    a_pulse_on_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && n_pulse |-> (r_mode != ST_SLEEP) && (n_mode == ST_SLEEP))
        else $error("sleep request without deep-sleep entry");

    // every way into active turns the display on
    a_active_display: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == ST_ACTIVE) |-> r_flags.display)
        else $error("active state with display off");

    // a processed transaction always produces a result next cycle
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("transaction processed but no result presented");

    // a delivered sleep request always reports deep sleep
    a_out_pulse_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_pulse |-> (r_out_state == ST_SLEEP))
        else $error("sleep request reported outside deep sleep");
`endif

endmodule
